@@ rtl/hpool_pkg.sv @@
`default_nettype none

package hpool_pkg;

   localparam int POOL_DEPTH = 128;
   localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
   localparam int RESET_SIZE = (POOL_DEPTH < 128) ? POOL_DEPTH : 128;

   localparam int MODE_W     = 2;
   localparam int HANDLE_W   = 32;
   localparam int GEN_W      = 16;
   localparam int HIDX_W     = 16;
   localparam int SLOT_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int SIZE_W     = 8;

   // One slot entry holds the live mark above the generation.
   localparam int SLOT_ENTRY_W = GEN_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   localparam logic CSR_REG_POOL_SIZE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic              init;
      logic [SIZE_W-1:0] wr_size;
      logic [SIZE_W-1:0] size;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [IDX_W-1:0] wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } stk_req_type;

   typedef struct packed {
      logic             live;
      logic [GEN_W-1:0] gen;
   } slot_entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      slot_entry_type   wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } gen_req_type;

endpackage

`default_nettype wire

@@ rtl/hpool_req_if.sv @@
`default_nettype none

interface hpool_req_if import hpool_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [HANDLE_W-1:0] handle;

   modport source (output valid, output mode, output handle, input ready);
   modport sink   (input valid, input mode, input handle, output ready);
endinterface

`default_nettype wire

@@ rtl/hpool_rsp_if.sv @@
`default_nettype none

interface hpool_rsp_if import hpool_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] handle_out;
   logic [SLOT_W-1:0]   slot_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output handle_out, output slot_index, output status,
                   input ready);
   modport sink   (input valid, input handle_out, input slot_index, input status,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/hpool_ram.sv @@
`default_nettype none

module hpool_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read data holds between reads.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/hpool_csr.sv @@
`default_nettype none

module hpool_csr import hpool_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_in;
   logic [SIZE_W-1:0] wr_size;
   logic              sel_size;
   logic              wr_fire;

   assign pready   = 1'b1;
   assign sel_size = (paddr[2] == CSR_REG_POOL_SIZE);
   assign wr_fire  = psel && penable && pwrite && sel_size;

   // A size of zero acts as one; anything above the depth acts as the depth.
   always_comb begin
      wr_size = pwdata[SIZE_W-1:0];
      if (wr_size == '0) begin
         wr_size = SIZE_W'(1);
      end else if (32'(pwdata[SIZE_W-1:0]) > 32'(POOL_DEPTH)) begin
         wr_size = SIZE_W'(POOL_DEPTH);
      end
      size_in = wr_fire ? wr_size : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(RESET_SIZE);
      end else begin
         size_ff <= size_in;
      end
   end

   assign prdata = (psel && !pwrite && sel_size) ? CSR_DATA_W'(size_ff) : '0;

   assign cfg.init    = wr_fire;
   assign cfg.wr_size = wr_size;
   assign cfg.size    = size_ff;

endmodule

`default_nettype wire

@@ rtl/hpool_engine.sv @@
`default_nettype none

module hpool_engine import hpool_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   hpool_req_if.sink             req,
   hpool_rsp_if.source           rsp,
   output stk_req_type           stk_req,
   input  wire logic [IDX_W-1:0] stk_rdata,
   output gen_req_type           gen_req,
   input  wire slot_entry_type   gen_rdata
);

   state_type           state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    low_ff, low_in;
   logic [IDX_W-1:0]    pop_ff, pop_in;
   logic [POOL_DEPTH-1:0] genv_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                req_fire;
   logic                out_free;
   logic [CNT_W-1:0]    top_pos;
   logic [IDX_W-1:0]    popped;
   logic [HIDX_W-1:0]   hidx;
   logic [IDX_W-1:0]    ex_idx;
   logic [GEN_W-1:0]    gen_old;
   logic [GEN_W-1:0]    gen_new;
   logic                slot_live;
   logic [CNT_W-1:0]    ex_slot;
   logic                handle_ok;
   logic                live_set;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign top_pos = count_ff - CNT_W'(1);

   // Entries below the low-water mark still hold their fill value.
   assign popped = (top_pos < low_ff) ?
                   IDX_W'(CNT_W'(cfg.size) - CNT_W'(1) - top_pos) : stk_rdata;

   assign hidx      = handle_ff[HIDX_W-1:0];
   assign ex_idx    = (mode_ff == MODE_ALLOC) ? pop_ff : IDX_W'(hidx - HIDX_W'(1));
   assign gen_old   = genv_ff[ex_idx] ? gen_rdata.gen : '0;
   assign slot_live = genv_ff[ex_idx] && gen_rdata.live;
   assign gen_new   = (gen_old == {GEN_W{1'b1}}) ? GEN_W'(1) : gen_old + GEN_W'(1);
   assign ex_slot   = CNT_W'({1'b0, ex_idx}) + CNT_W'(1);

   assign handle_ok = (hidx != '0) && (hidx <= HIDX_W'(cfg.size)) && slot_live &&
                      (gen_old == handle_ff[HANDLE_W-1:HIDX_W]);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      low_in        = low_ff;
      pop_in        = pop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      live_set      = 1'b0;

      stk_req.we         = 1'b0;
      stk_req.waddr      = IDX_W'(count_ff);
      stk_req.wdata      = ex_idx;
      stk_req.re         = req_fire;
      stk_req.raddr      = IDX_W'(top_pos);
      gen_req.we         = 1'b0;
      gen_req.waddr      = ex_idx;
      gen_req.wdata.live = 1'b1;
      gen_req.wdata.gen  = gen_new;
      gen_req.re         = 1'b0;
      gen_req.raddr      = IDX_W'(req.handle[HIDX_W-1:0] - HIDX_W'(1));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in     = req.mode;
               handle_in   = req.handle;
               gen_req.re  = (req.mode != MODE_ALLOC);
               state_in    = (req.mode == MODE_ALLOC) ? ST_POP : ST_EXEC;
            end
         end
         ST_POP: begin
            pop_in        = popped;
            gen_req.re    = 1'b1;
            gen_req.raddr = popped;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_slot_in   = '0;
               rsp_status_in = STATUS_BAD;
               state_in      = ST_IDLE;
               case (mode_ff)
                  MODE_ALLOC: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        gen_req.we    = 1'b1;
                        live_set      = 1'b1;
                        count_in      = top_pos;
                        if (top_pos < low_ff) begin
                           low_in = top_pos;
                        end
                        rsp_handle_in = {gen_new, HIDX_W'(ex_slot)};
                        rsp_slot_in   = SLOT_W'(ex_slot);
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  MODE_RELEASE: begin
                     if (handle_ok) begin
                        // The slot keeps its generation and loses its live mark.
                        gen_req.we         = 1'b1;
                        gen_req.wdata.live = 1'b0;
                        gen_req.wdata.gen  = gen_old;
                        if (count_ff < CNT_W'(POOL_DEPTH)) begin
                           stk_req.we = 1'b1;
                           count_in   = count_ff + CNT_W'(1);
                        end
                        rsp_handle_in = handle_ff;
                        rsp_slot_in   = SLOT_W'(hidx);
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  MODE_LOOKUP: begin
                     if (handle_ok) begin
                        rsp_handle_in = handle_ff;
                        rsp_slot_in   = SLOT_W'(hidx);
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_BAD;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.init) begin
         count_in = CNT_W'(cfg.wr_size);
         low_in   = CNT_W'(cfg.wr_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(RESET_SIZE);
         low_ff       <= CNT_W'(RESET_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A slot entry counts as written once an alloc has stored it.
   always_ff @(posedge clock) begin
      if (reset || cfg.init) begin
         genv_ff <= '0;
      end else if (live_set) begin
         genv_ff[ex_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      handle_ff     <= handle_in;
      pop_ff        <= pop_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.handle_out = rsp_handle_ff;
   assign rsp.slot_index = rsp_slot_ff;
   assign rsp.status     = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/generational_handle_pool.sv @@
// Channel   Direction  Transfer when       Carries
// req       in         valid && ready      mode, handle
// rsp       out        valid && ready      handle_out, slot_index, status
// csr       in         psel/penable/pwrite APB write or read of pool_size
//
// A release or lookup goes from its transfer straight to the execute step, where the result
// is registered; an alloc passes a pop step first, because the free-stack pop read must
// finish before the generation read of the popped slot can be issued. Ready returns in
// the cycle after the result is registered.
// Reset and pool_size writes take effect at once: per-slot written bits are flops, and a
// low-water mark stands in for the initial free-stack contents, so there is no sweep.
// The result sits in an output register, so a new request is taken while the last result
// waits; the execute step holds until that register is free.
`default_nettype none

module generational_handle_pool import hpool_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hpool_req_if.sink                  req,
   hpool_rsp_if.source                rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type          cfg;
   stk_req_type      stk_req;
   gen_req_type      gen_req;
   logic [IDX_W-1:0] stk_rdata;
   slot_entry_type   gen_rdata;

   // The pool_size register; its write also restarts the free stack and clears all slots.
   hpool_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The sequencer: accept, optional pop read, then one read-modify-write step.
   hpool_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req),
      .rsp       (rsp),
      .stk_req   (stk_req),
      .stk_rdata (stk_rdata),
      .gen_req   (gen_req),
      .gen_rdata (gen_rdata)
   );

   // Free stack of slot indices, stored as index minus one.
   hpool_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (stk_req.we),
      .waddr (stk_req.waddr),
      .wdata (stk_req.wdata),
      .re    (stk_req.re),
      .raddr (stk_req.raddr),
      .rdata (stk_rdata)
   );

   // Per-slot live mark and generation counter; an entry never written since reset reads
   // as not live with generation zero through its written bit in the engine.
   hpool_ram #(
      .WIDTH (SLOT_ENTRY_W),
      .DEPTH (POOL_DEPTH)
   ) u_gen_ram (
      .clock (clock),
      .we    (gen_req.we),
      .waddr (gen_req.waddr),
      .wdata (gen_req.wdata),
      .re    (gen_req.re),
      .raddr (gen_req.raddr),
      .rdata (gen_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/hpool_checker.sv @@
`default_nettype none

module hpool_checker import hpool_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [HANDLE_W-1:0] handle_out,
   input wire logic [SLOT_W-1:0]   slot_index,
   input wire logic [STATUS_W-1:0] status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(handle_out) &&
                                  $stable(slot_index) && $stable(status))
      else $error("result changed while stalled");

   a_ok_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_OK |->
         slot_index != '0 && handle_out[HIDX_W-1:0] == HIDX_W'(slot_index) &&
         handle_out[HANDLE_W-1:HIDX_W] != '0)
      else $error("successful result carries a bad handle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STATUS_OK |-> handle_out == '0 && slot_index == '0)
      else $error("failed result is not cleared");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in flight");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind generational_handle_pool hpool_checker u_hpool_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .handle_out (rsp.handle_out),
   .slot_index (rsp.slot_index),
   .status     (rsp.status)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

import hpool_pkg::*;

typedef struct packed {
   logic [HANDLE_W-1:0] handle_out;
   logic [SLOT_W-1:0]   slot_index;
   logic [STATUS_W-1:0] status;
} pool_result_type;

// Shadow copy of the pool state that works out the result of every accepted request.
class pool_mirror_type;
   int unsigned         pool_sz;
   int unsigned         free_idx[POOL_DEPTH];
   int unsigned         free_cnt;
   logic [GEN_W-1:0]    gen_of[POOL_DEPTH+1];
   bit                  live[POOL_DEPTH+1];
   logic [HANDLE_W-1:0] last_freed;
   pool_result_type     awaited[$];
   int                  errors;
   int                  n_requests;
   int                  n_ok;
   int                  n_full;
   int                  n_bad;

   function new();
      pool_sz    = RESET_SIZE;
      last_freed = '0;
      refill();
   endfunction

   function void refill();
      free_cnt = 0;
      for (int i = 0; i <= POOL_DEPTH; i++) begin
         gen_of[i] = '0;
         live[i]   = 1'b0;
      end
      for (int k = pool_sz; k >= 1; k--) begin
         free_idx[free_cnt] = k;
         free_cnt++;
      end
   endfunction

   function void set_pool_size(logic [CSR_DATA_W-1:0] value);
      int unsigned v;
      v = value[SIZE_W-1:0];
      if (v < 1) v = 1;
      if (v > POOL_DEPTH) v = POOL_DEPTH;
      pool_sz = v;
      refill();
   endfunction

   function bit handle_valid(logic [HANDLE_W-1:0] h);
      int unsigned idx;
      idx = h[HIDX_W-1:0];
      if (idx == 0 || idx > pool_sz) return 1'b0;
      if (!live[idx]) return 1'b0;
      return gen_of[idx] == h[HANDLE_W-1:HIDX_W];
   endfunction

   function void note_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] h);
      pool_result_type r;
      int unsigned  idx;
      logic [GEN_W-1:0] g;
      r = '{handle_out: '0, slot_index: '0, status: STATUS_BAD};
      idx = h[HIDX_W-1:0];
      case (mode)
         MODE_ALLOC: begin
            if (free_cnt == 0) begin
               r.status = STATUS_FULL;
            end else begin
               free_cnt--;
               idx = free_idx[free_cnt];
               g = gen_of[idx] + 1'b1;
               if (g == '0) g = 1;
               gen_of[idx] = g;
               live[idx]   = 1'b1;
               r = '{handle_out: {g, HIDX_W'(idx)}, slot_index: SLOT_W'(idx),
                     status: STATUS_OK};
            end
         end
         MODE_RELEASE: begin
            if (handle_valid(h)) begin
               live[idx] = 1'b0;
               if (free_cnt < POOL_DEPTH) begin
                  free_idx[free_cnt] = idx;
                  free_cnt++;
               end
               last_freed = h;
               r = '{handle_out: h, slot_index: SLOT_W'(idx), status: STATUS_OK};
            end
         end
         MODE_LOOKUP: begin
            if (handle_valid(h))
               r = '{handle_out: h, slot_index: SLOT_W'(idx), status: STATUS_OK};
         end
         default: ;
      endcase
      n_requests++;
      awaited.push_back(r);
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task check_result(logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] s, logic [STATUS_W-1:0] st);
      pool_result_type want;
      if (awaited.size() == 0) begin
         report_mismatch("result with nothing pending (handle_out)", h, 0);
      end else begin
         want = awaited.pop_front();
         if (h !== want.handle_out) report_mismatch("handle_out", h, want.handle_out);
         if (s !== want.slot_index) report_mismatch("slot_index", s, want.slot_index);
         if (st !== want.status) report_mismatch("status", st, want.status);
         case (want.status)
            STATUS_OK:   n_ok++;
            STATUS_FULL: n_full++;
            default:     n_bad++;
         endcase
      end
   endtask

   function int awaiting();
      return awaited.size();
   endfunction
endclass

module testbench;
   import hpool_pkg::*;

   // The mode value that the block does not define; it must be rejected.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] POOL_SIZE_ADDR =
      CSR_ADDR_W'({CSR_REG_POOL_SIZE, 2'b00});
   localparam int ITEMS_PER_PHASE = 275;
   localparam int NUM_PHASES      = 6;
   // An alloc passes through its accept, pop and execute states; these spare cycles cover anything still in flight.
   localparam int SETTLE_CYCLES   = 8;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hpool_req_if req_ch ();
   hpool_rsp_if rsp_ch ();

   generational_handle_pool dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   pool_mirror_type book = new();

   // Idle percentages for the two sides, changed between phases by the main sequence.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // A long receiver hold-off is requested here and counted down by the receiver process.
   int hold_request  = 0;
   int sizes_used    = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: ready changes on the falling edge only. A pending hold-off request takes
   // priority over the random idling, so the block's output register and its pipeline fill
   // up and the request channel has to stall.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         book.check_result(rsp_ch.handle_out, rsp_ch.slot_index, rsp_ch.status);
   end

   // Offer one request, idling first at random, and note it in the mirror once the
   // transfer has happened. Valid stays high into the next call when there is no idling.
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] h);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= mode;
      req_ch.handle <= h;
      do @(posedge clock); while (!req_ch.ready);
      book.note_request(mode, h);
   endtask

   task automatic quiet_sender();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Waits for every predicted result, then lets the pipeline settle.
   task automatic wait_drained();
      while (book.awaiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: a setup cycle, then the access cycle which completes when pready is high.
   task automatic write_pool_size(input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= POOL_SIZE_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      book.set_pool_size(value);
      sizes_used++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random request shaped by the mirror's state: mostly allocs and well-formed releases
   // and lookups of live handles, the rest stale, out-of-range, doubled or garbage handles.
   task automatic pick_request(output logic [MODE_W-1:0] mode, output logic [HANDLE_W-1:0] h);
      int unsigned live_list[$];
      int unsigned roll;
      int unsigned idx;
      logic [GEN_W-1:0] g;
      roll = $urandom_range(0, 99);
      for (int unsigned i = 1; i <= book.pool_sz; i++)
         if (book.live[i]) live_list.push_back(i);
      mode = MODE_ALLOC;
      h    = $urandom();
      if (roll < 38) begin
         mode = MODE_ALLOC;
      end else if (roll < 82 && live_list.size() > 0) begin
         idx  = live_list[$urandom_range(0, live_list.size() - 1)];
         mode = (roll < 62) ? MODE_RELEASE : MODE_LOOKUP;
         h    = {book.gen_of[idx], HIDX_W'(idx)};
      end else begin
         mode = $urandom_range(0, 1) ? MODE_RELEASE : MODE_LOOKUP;
         idx  = $urandom_range(1, book.pool_sz);
         case ($urandom_range(0, 6))
            0: h = {GEN_W'($urandom()), HIDX_W'(0)};
            1: h = {GEN_W'($urandom()), HIDX_W'($urandom_range(book.pool_sz + 1, 65535))};
            2: begin
               // Generation flipped in a random nonzero set of bits.
               g = book.gen_of[idx] ^ GEN_W'($urandom_range(1, 65535));
               h = {g, HIDX_W'(idx)};
            end
            3: h = {book.gen_of[idx], HIDX_W'(idx)};
            4: h = book.last_freed;
            5: mode = MODE_UNUSED;
            default: ;
         endcase
      end
   endtask

   initial begin
      logic [MODE_W-1:0]     mode;
      logic [HANDLE_W-1:0]   h;
      logic [CSR_DATA_W-1:0] phase_size[NUM_PHASES];

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.mode   = MODE_ALLOC;
      req_ch.handle = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed checks on the reset pool of full size. The first alloc must hand out
      // index 1 with generation 1; the handle input of an alloc is ignored.
      send_request(MODE_LOOKUP, 32'h0000_0000);
      send_request(MODE_ALLOC, 32'hFFFF_FFFF);
      send_request(MODE_LOOKUP, 32'h0001_0001);
      send_request(MODE_LOOKUP, 32'h0002_0001);   // wrong generation
      send_request(MODE_RELEASE, 32'h0001_0001);
      send_request(MODE_RELEASE, 32'h0001_0001);  // double release
      send_request(MODE_LOOKUP, 32'h0001_0001);   // slot no longer live
      send_request(MODE_ALLOC, 32'h0000_0000);
      send_request(MODE_ALLOC, 32'h0000_0000);
      send_request(MODE_RELEASE, 32'h0001_0081);  // index above the pool size
      send_request(MODE_LOOKUP, 32'hFFFF_FFFF);
      send_request(MODE_UNUSED, 32'hFFFF_FFFF);
      send_request(MODE_RELEASE, 32'h0002_0000);  // index zero
      send_request(MODE_LOOKUP, 32'h0001_FF02);   // high index bits set
      send_request(MODE_LOOKUP, 32'h0001_0002);
      quiet_sender();
      wait_drained();

      // A size of zero acts as one: the second alloc finds the stack empty.
      write_pool_size(32'd0);
      send_request(MODE_ALLOC, 32'h0000_0000);
      send_request(MODE_ALLOC, 32'h0000_0000);
      send_request(MODE_RELEASE, 32'h0001_0001);
      send_request(MODE_ALLOC, 32'h0000_0000);
      quiet_sender();
      wait_drained();

      // A size above the pool depth is clipped to the depth.
      write_pool_size(32'd255);
      send_request(MODE_LOOKUP, 32'h0000_0080);
      send_request(MODE_ALLOC, 32'h0000_0000);
      quiet_sender();
      wait_drained();

      // Random phases, each under its own pool size. The first pair idles the receiver
      // heavily, the second the sender, the last pair has no random idling, only a hold-off.
      phase_size = '{32'd255, 32'd3, $urandom(), 32'd1, 32'd128,
                     CSR_DATA_W'($urandom_range(2, 127))};
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_pool_size(phase_size[p]);
         send_idle_pct = (p < 2) ? 31 : (p < 4) ? 70 : 0;
         recv_idle_pct = (p < 2) ? 70 : (p < 4) ? 31 : 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 1 && n == 137) begin
               // The sender stops until everything it sent has come back.
               quiet_sender();
               wait_drained();
            end
            if (p == 4 && n == 100) hold_request = 300;
            pick_request(mode, h);
            send_request(mode, h);
         end
         quiet_sender();
         wait_drained();
      end

      if (book.awaiting() != 0)
         book.report_mismatch("results never returned (count)", book.awaiting(), 0);
      $display("Checked %0d requests across %0d pool sizes, with stale, doubled and bad handles.",
               book.n_requests, sizes_used);
      $display("Results: %0d accepted, %0d pool full, %0d rejected handles; %0d mismatches.",
               book.n_ok, book.n_full, book.n_bad, book.errors);
      if (book.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Safety net: a run that hangs is stopped with a failure.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
